>>> src/ucmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ucmc_pkg;

   localparam int unsigned MODE_CODES = 8;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [PHASE_W-1:0] PH_DETACHED   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ATTACH_REQ = 3'd1;
   localparam logic [PHASE_W-1:0] PH_WAIT_HOST  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CONFIGURED = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DETACH_REQ = 3'd4;

   localparam logic [1:0] EV_MODE_REQ   = 2'd0;
   localparam logic [1:0] EV_HOST_CFG   = 2'd1;
   localparam logic [1:0] EV_HOST_CMD   = 2'd2;
   localparam logic [1:0] EV_PROC_TICK  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACH_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAG_IDLE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAG_MODE      = 2'd2;

   localparam logic [TIME_W-1:0] ATTACH_TIMEOUT_RST = 32'd10000;
   localparam logic [TIME_W-1:0] DIAG_IDLE_RST      = 32'd120000;
   localparam logic [MODE_W-1:0] DIAG_MODE_RST      = 3'd1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [MODE_W-1:0] mode;
      logic [TIME_W-1:0] now_ms;
      logic              attach_ok;
      logic              detach_ok;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0] attach_timeout_ms;
      logic [TIME_W-1:0] diag_idle_limit_ms;
      logic [MODE_W-1:0] diag_mode_code;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [MODE_W-1:0]  active_mode;
      logic [MODE_W-1:0]  pending_mode;
      logic [TIME_W-1:0]  attach_time;
      logic [TIME_W-1:0]  last_cmd_time;
   } ctl_state_type;

   typedef struct packed {
      logic               accepted;
      logic [PHASE_W-1:0] ctl_state;
      logic [MODE_W-1:0]  cur_mode;
   } result_type;

endpackage

`default_nettype wire

>>> src/ucmc_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ucmc_step import ucmc_pkg::*; (
   input  item_type      item,
   input  cfg_type       cfg,
   input  ctl_state_type cur,
   output ctl_state_type nxt,
   output result_type    result
);

   logic              acc;
   logic [TIME_W-1:0] since_attach;
   logic [TIME_W-1:0] since_cmd;
   logic              attach_expired;
   logic              diag_expired;
   logic              mode_bad;

   assign since_attach   = item.now_ms - cur.attach_time;
   assign since_cmd      = item.now_ms - cur.last_cmd_time;
   assign attach_expired = (cur.phase == PH_WAIT_HOST) &&
                           (since_attach >= cfg.attach_timeout_ms);
   assign diag_expired   = (cur.phase == PH_CONFIGURED) &&
                           (cur.active_mode == cfg.diag_mode_code) &&
                           (since_cmd >= cfg.diag_idle_limit_ms);
   assign mode_bad       = 9'(item.mode) >= 9'(MODE_CODES);

   always_comb begin
      nxt = cur;
      acc = 1'b0;
      case (item.req_type)
         EV_MODE_REQ: begin
            if (!mode_bad) begin
               acc = 1'b1;
               if (item.mode == '0) begin
                  nxt.pending_mode = '0;
                  if (cur.phase == PH_DETACHED) begin
                     nxt.active_mode = '0;
                  end else begin
                     nxt.phase = PH_DETACH_REQ;
                  end
               end else if ((cur.phase != PH_DETACHED) && (cur.active_mode != '0) &&
                            (cur.active_mode != item.mode)) begin
                  nxt.pending_mode = item.mode;
                  nxt.phase        = PH_DETACH_REQ;
               end else begin
                  nxt.pending_mode  = '0;
                  nxt.active_mode   = item.mode;
                  nxt.attach_time   = item.now_ms;
                  nxt.last_cmd_time = item.now_ms;
                  nxt.phase         = PH_ATTACH_REQ;
               end
            end
         end
         EV_HOST_CFG: begin
            nxt.phase = PH_CONFIGURED;
         end
         EV_HOST_CMD: begin
            nxt.last_cmd_time = item.now_ms;
         end
         EV_PROC_TICK: begin
            if (cur.phase == PH_ATTACH_REQ) begin
               if (item.attach_ok) begin
                  nxt.phase = PH_WAIT_HOST;
                  acc       = 1'b1;
               end
            end else if ((cur.phase == PH_DETACH_REQ) || attach_expired || diag_expired) begin
               if (!item.detach_ok) begin
                  nxt.phase = PH_DETACH_REQ;
               end else begin
                  acc              = 1'b1;
                  nxt.pending_mode = '0;
                  if (cur.pending_mode != '0) begin
                     nxt.active_mode   = cur.pending_mode;
                     nxt.attach_time   = item.now_ms;
                     nxt.last_cmd_time = item.now_ms;
                     nxt.phase         = PH_ATTACH_REQ;
                  end else begin
                     nxt.active_mode = '0;
                     nxt.phase       = PH_DETACHED;
                  end
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   assign result.accepted  = acc;
   assign result.ctl_state = nxt.phase;
   assign result.cur_mode  = nxt.active_mode;

endmodule

`default_nettype wire

>>> src/usb_class_mode_controller_unit.sv
// An accepted req item reaches rsp_valid through the input register and then the result register.
// Throughput: 1 item per cycle unless rsp_stall holds the output; the step logic between the two
// registers reads and updates the controller state in the same cycle, so items follow back to back.
// Reset (synchronous, active high): phase detached, no active or queued mode, times 0,
// registers to 10000 ms, 120000 ms and diagnostic mode 1; both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module usb_class_mode_controller_unit import ucmc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_type,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [TIME_W-1:0]    req_now_ms,
   input  wire logic                 req_attach_ok,
   input  wire logic                 req_detach_ok,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_accepted,
   output logic [PHASE_W-1:0]        rsp_ctl_state,
   output logic [MODE_W-1:0]         rsp_cur_mode,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_wdata
);

   cfg_type       cfg_ff,   cfg_in;
   ctl_state_type state_ff, state_in;
   item_type      s1_item_ff, s1_item_in;
   logic          s1_valid_ff, s1_valid_in;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   ctl_state_type step_state;
   result_type    step_result;
   logic          out_open;
   logic          advance;
   logic          req_take;

   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_open;
   assign req_stall = s1_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   ucmc_step u_step (
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .nxt    (step_state),
      .result (step_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ATTACH_TIMEOUT: cfg_in.attach_timeout_ms  = csr_wdata;
            CSR_DIAG_IDLE:      cfg_in.diag_idle_limit_ms = csr_wdata;
            CSR_DIAG_MODE:      cfg_in.diag_mode_code     = csr_wdata[MODE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_item_in = s1_item_ff;
      s1_valid_in = s1_valid_ff && !advance;
      if (req_take) begin
         s1_item_in.req_type  = req_type;
         s1_item_in.mode      = req_mode;
         s1_item_in.now_ms    = req_now_ms;
         s1_item_in.attach_ok = req_attach_ok;
         s1_item_in.detach_ok = req_detach_ok;
         s1_valid_in          = 1'b1;
      end
   end

   assign state_in     = advance ? step_state : state_ff;
   assign rsp_in       = advance ? step_result : rsp_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attach_timeout_ms  <= ATTACH_TIMEOUT_RST;
         cfg_ff.diag_idle_limit_ms <= DIAG_IDLE_RST;
         cfg_ff.diag_mode_code     <= DIAG_MODE_RST;
         state_ff.phase            <= PH_DETACHED;
         state_ff.active_mode      <= '0;
         state_ff.pending_mode     <= '0;
         state_ff.attach_time      <= '0;
         state_ff.last_cmd_time    <= '0;
         s1_valid_ff               <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_ff.accepted;
   assign rsp_ctl_state = rsp_ff.ctl_state;
   assign rsp_cur_mode  = rsp_ff.cur_mode;

`ifndef NO_ASSERTIONS
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("controller state changed without an item");

   a_attach_has_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_ATTACH_REQ || state_ff.phase == PH_WAIT_HOST) |->
      (state_ff.active_mode != '0))
      else $error("attach phase without an active mode");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item not presented");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with room available");
`endif

endmodule

`default_nettype wire
